// ===== sv/swlap_pkg.sv =====
// ----------------------------------------------------------------------------
// swlap_pkg
// shared types, constants and segment encoding for the stopwatch core
// ----------------------------------------------------------------------------
`default_nettype none

package swlap_pkg;

  localparam int unsigned CountWidth = 29;

  // sixty minutes in 10 us counts
  localparam logic [CountWidth-1:0] LIMIT_COUNTS = 29'd360000000;

  // reciprocals for constant division, exact over the reachable ranges
  // (x >> 3) * RECIP_HUND >> 33 == x / 1000 for 29-bit x
  localparam logic [26:0] RECIP_HUND = 27'd68719477;
  // (x >> 2) * RECIP_SEC >> 23 == x / 100 for 20-bit x
  localparam logic [18:0] RECIP_SEC  = 19'd335545;
  // (x >> 2) * RECIP_MIN >> 15 == x / 60 for 13-bit x
  localparam logic [11:0] RECIP_MIN  = 12'd2185;
  // x * RECIP_TEN >> 11 == x / 10 for x below 100
  localparam logic [7:0]  RECIP_TEN  = 8'd205;

  typedef struct packed {
    logic [3:0] keys;
    logic       show_lap;
    logic       timer_event;
  } item_t;

  typedef struct packed {
    logic [15:0] minute_segments;
    logic [31:0] second_segments;
    logic        tick_ack;
    logic        is_counting;
  } result_t;

  // one classified poll cycle, passed from front to back
  typedef struct packed {
    logic [CountWidth-1:0] shown;
    logic                  ack;
    logic                  running;
  } entry_t;

  // segment a in bit 0 .. segment g in bit 6
  function automatic logic [7:0] seg_pattern(input logic [3:0] d);
    logic [7:0] p;
    case (d)
      4'd0:    p = 8'h3F;
      4'd1:    p = 8'h06;
      4'd2:    p = 8'h5B;
      4'd3:    p = 8'h4F;
      4'd4:    p = 8'h66;
      4'd5:    p = 8'h6D;
      4'd6:    p = 8'h7D;
      4'd7:    p = 8'h07;
      4'd8:    p = 8'h7F;
      4'd9:    p = 8'h6F;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // two-digit value below 100 to tens and units patterns
  function automatic logic [15:0] pair_segments(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'(RECIP_TEN);
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {seg_pattern(tens), seg_pattern(units[3:0])};
  endfunction

endpackage

`default_nettype wire

// ===== sv/swlap_front.sv =====
// ----------------------------------------------------------------------------
// swlap_front
// key handling, counter state and choice of the displayed value
// ----------------------------------------------------------------------------
`default_nettype none

module swlap_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             take,
  input  wire swlap_pkg::item_t item,
  output swlap_pkg::entry_t     entry
);

  logic [swlap_pkg::CountWidth-1:0] elapsed;
  logic [swlap_pkg::CountWidth-1:0] lap_value;
  logic                             running;

  logic [swlap_pkg::CountWidth-1:0] elapsed_next;
  logic [swlap_pkg::CountWidth-1:0] lap_value_next;
  logic                             running_next;

  logic [swlap_pkg::CountWidth-1:0] lap_cap;
  logic [swlap_pkg::CountWidth-1:0] elapsed_clr;
  logic                             clear;
  logic                             ack;

  always_comb begin
    // start then stop, stop wins
    running_next = item.keys[1] ? 1'b0 : (item.keys[0] ? 1'b1 : running);
    lap_cap      = item.keys[2] ? elapsed : lap_value;
    clear        = item.keys[3] || (elapsed >= swlap_pkg::LIMIT_COUNTS);
    elapsed_clr  = clear ? '0 : elapsed;
    lap_value_next = clear ? '0 : lap_cap;
    ack          = running_next && item.timer_event;
    elapsed_next = ack ? elapsed_clr + 29'd1 : elapsed_clr;

    // display shows the value from before the increment
    entry.shown   = item.show_lap ? lap_value_next : elapsed_clr;
    entry.ack     = ack;
    entry.running = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed   <= '0;
      lap_value <= '0;
      running   <= 1'b0;
    end else if (take) begin
      elapsed   <= elapsed_next;
      lap_value <= lap_value_next;
      running   <= running_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/swlap_queue.sv =====
// ----------------------------------------------------------------------------
// swlap_queue
// two-entry queue between the front and the display pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module swlap_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire swlap_pkg::entry_t push_entry,
  input  wire logic              pop,
  output logic                   full,
  output logic                   head_valid,
  output swlap_pkg::entry_t      head
);

  swlap_pkg::entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = fill[1];
  assign head_valid = (fill != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/swlap_back.sv =====
// ----------------------------------------------------------------------------
// swlap_back
// split of the shown count into digits and seven-segment encoding
// ----------------------------------------------------------------------------
`default_nettype none

module swlap_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire swlap_pkg::entry_t head,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output swlap_pkg::result_t     result
);

  logic advance;

  logic v1, v2, v3, v4;

  // stage 1: hundredths count
  logic [19:0] q1;
  logic        ack1, run1;
  // stage 2: whole seconds
  logic [19:0] q2;
  logic [12:0] sec2;
  logic        ack2, run2;
  // stage 3: minutes and hundredths
  logic [12:0] sec3;
  logic [6:0]  mm3, hh3;
  logic        ack3, run3;
  // stage 4: seconds within the minute
  logic [5:0]  ss4;
  logic [6:0]  mm4, hh4;
  logic        ack4, run4;

  logic [52:0] prod1;
  logic [36:0] prod2;
  logic [22:0] prod3;
  logic [19:0] hund_rem;
  logic [12:0] sec_rem;

  assign advance = !result_valid || !result_stall;
  assign pop     = advance && head_valid;

  assign prod1    = 53'(head.shown[28:3]) * 53'(swlap_pkg::RECIP_HUND);
  assign prod2    = 37'(q1[19:2]) * 37'(swlap_pkg::RECIP_SEC);
  assign prod3    = 23'(sec2[12:2]) * 23'(swlap_pkg::RECIP_MIN);
  assign hund_rem = q2 - 20'(sec2) * 20'd100;
  assign sec_rem  = sec3 - 13'(mm3) * 13'd60;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else if (advance) begin
      v1           <= head_valid;
      v2           <= v1;
      v3           <= v2;
      v4           <= v3;
      result_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      q1   <= prod1[52:33];
      ack1 <= head.ack;
      run1 <= head.running;

      q2   <= q1;
      sec2 <= prod2[35:23];
      ack2 <= ack1;
      run2 <= run1;

      sec3 <= sec2;
      mm3  <= prod3[21:15];
      hh3  <= hund_rem[6:0];
      ack3 <= ack2;
      run3 <= run2;

      ss4  <= sec_rem[5:0];
      mm4  <= mm3;
      hh4  <= hh3;
      ack4 <= ack3;
      run4 <= run3;

      result.minute_segments <= swlap_pkg::pair_segments(mm4);
      result.second_segments <= {swlap_pkg::pair_segments(7'(ss4)),
                                 swlap_pkg::pair_segments(hh4)};
      result.tick_ack        <= ack4;
      result.is_counting     <= run4;
    end
  end

endmodule

`default_nettype wire

// ===== sv/stopwatch_lap_seven_segment_core.sv =====
// ----------------------------------------------------------------------------
// stopwatch_lap_seven_segment_core
// stopwatch with lap memory and seven-segment display patterns
// ----------------------------------------------------------------------------
// one input transaction is one poll cycle: keys (start, stop, lap, clear,
// applied in that order), a lap-display switch and a pending timer tick.
// each input transaction gives exactly one result transaction holding the
// minute, second and hundredth digit patterns of the shown value, the tick
// acknowledge and the running flag. one count is 10 us; the count clears
// itself when it reaches sixty minutes.
// the front updates the counter state as the transaction is taken and hands
// the shown value to a two-entry queue; the back splits it into digits over
// a five-register pipeline (three reciprocal multiplies, two remainder steps,
// then the digit and segment encode into the output register).
// a transaction passes the queue, then the five back registers, before its
// result is offered. throughput: one transaction per cycle unless stalled.
// a stall on the result side holds the whole back pipeline and its output;
// the queue then fills and item_stall rises two transactions later.
// reset (synchronous) stops the watch, zeroes elapsed and lap values and
// empties the queue and pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module stopwatch_lap_seven_segment_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire swlap_pkg::item_t   item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output swlap_pkg::result_t      result
);

  logic              take;
  logic              q_full;
  logic              head_valid;
  logic              pop;
  swlap_pkg::entry_t entry;
  swlap_pkg::entry_t head;

  // input side only waits on queue space
  assign item_stall = q_full;
  assign take       = item_valid && !q_full;

  swlap_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .item  (item),
    .entry (entry)
  );

  swlap_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .push_entry (entry),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  swlap_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
